>>> hdl/simd_shift_unit_128_defines.svh
// Assertion macros shared by the RTL.
`ifndef SIMD_SHIFT_UNIT_128_DEFINES_SVH
`define SIMD_SHIFT_UNIT_128_DEFINES_SVH

// Same-cycle implication.
`define SSU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define SSU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/ssu_pkg.sv
package ssu_pkg;

  typedef enum logic [4:0] {
    CMD_DSRA   = 5'd0,
    CMD_DSLL   = 5'd1,
    CMD_DSLL32 = 5'd2,
    CMD_DSLLV  = 5'd3,
    CMD_DSRA32 = 5'd4,
    CMD_DSRAV  = 5'd5,
    CMD_DSRL   = 5'd6,
    CMD_DSRL32 = 5'd7,
    CMD_DSRLV  = 5'd8,
    CMD_SLL    = 5'd9,
    CMD_SLLV   = 5'd10,
    CMD_SRA    = 5'd11,
    CMD_SRAV   = 5'd12,
    CMD_SRL    = 5'd13,
    CMD_SRLV   = 5'd14,
    CMD_PSLLH  = 5'd15,
    CMD_PSLLVW = 5'd16,
    CMD_PSLLW  = 5'd17,
    CMD_PSRAH  = 5'd18,
    CMD_PSRAVW = 5'd19,
    CMD_PSRAW  = 5'd20,
    CMD_PSRLH  = 5'd21,
    CMD_PSRLVW = 5'd22,
    CMD_PSRLW  = 5'd23,
    CMD_QFSRV  = 5'd24
  } cmd_t;

  typedef enum logic [2:0] {
    CLS_NONE,
    CLS_DW,
    CLS_W,
    CLS_PH,
    CLS_PW,
    CLS_VW,
    CLS_FUN
  } cls_t;

  typedef enum logic [1:0] {
    KIND_SLL,
    KIND_SRA,
    KIND_SRL
  } kind_t;

  typedef struct packed {
    cls_t        cls;
    kind_t       kind;
    logic [7:0]  amt_a;
    logic [4:0]  amt_b;
  } ssu_ctl_t;

  localparam int unsigned DW = 64;
  localparam int unsigned QW = 128;
  localparam int unsigned FUN_W = 256;
  localparam int unsigned MID_W = QW + 8;

  localparam logic [7:0] DW_HIGH_OFFSET = 8'd32;
  localparam logic [7:0] COARSE_MASK_A = 8'hF8;
  localparam logic [4:0] COARSE_MASK_B = 5'h18;
  localparam logic [7:0] FINE_MASK_A = 8'h07;
  localparam logic [4:0] FINE_MASK_B = 5'h07;

  function automatic logic [63:0] dw_sh(logic [63:0] x, kind_t k, logic [5:0] s);
    logic [63:0] r;
    case (k)
      KIND_SLL: r = x << s;
      KIND_SRA: r = 64'($signed(x) >>> s);
      KIND_SRL: r = x >> s;
      default:  r = x;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] word_sh(logic [31:0] x, kind_t k, logic [4:0] s);
    logic [31:0] r;
    case (k)
      KIND_SLL: r = x << s;
      KIND_SRA: r = 32'($signed(x) >>> s);
      KIND_SRL: r = x >> s;
      default:  r = x;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] half_sh(logic [15:0] x, kind_t k, logic [3:0] s);
    logic [15:0] r;
    case (k)
      KIND_SLL: r = x << s;
      KIND_SRA: r = 16'($signed(x) >>> s);
      KIND_SRL: r = x >> s;
      default:  r = x;
    endcase
    return r;
  endfunction

  // One step of the lane shifters; callers pre-mask the amounts.
  function automatic logic [127:0] lane_shift(logic [127:0] d, cls_t cls, kind_t k,
                                               logic [7:0] sa, logic [4:0] sb);
    logic [127:0] r;
    r = d;
    case (cls)
      CLS_DW: r[63:0] = dw_sh(d[63:0], k, sa[5:0]);
      CLS_W:  r[31:0] = word_sh(d[31:0], k, sa[4:0]);
      CLS_VW: begin
        r[31:0]  = word_sh(d[31:0], k, sa[4:0]);
        r[95:64] = word_sh(d[95:64], k, sb);
      end
      CLS_PW: begin
        for (int i = 0; i < 4; i++) r[32*i +: 32] = word_sh(d[32*i +: 32], k, sa[4:0]);
      end
      CLS_PH: begin
        for (int i = 0; i < 8; i++) r[16*i +: 16] = half_sh(d[16*i +: 16], k, sa[3:0]);
      end
      default: r = d;
    endcase
    return r;
  endfunction

  function automatic logic [63:0] sext32(logic [31:0] x);
    return {{32{x[31]}}, x};
  endfunction

endpackage

>>> hdl/ssu_if.sv
interface ssu_in_if import ssu_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [4:0]  cmd;
  logic [63:0] rt_low;
  logic [63:0] rt_high;
  logic [63:0] rs_low;
  logic [63:0] rs_high;
  logic [4:0]  imm_amount;
  logic [7:0]  funnel_amount;

  modport source (output valid, cmd, rt_low, rt_high, rs_low, rs_high, imm_amount,
                  funnel_amount, input ready);
  modport sink (input valid, cmd, rt_low, rt_high, rs_low, rs_high, imm_amount,
                funnel_amount, output ready);
endinterface

interface ssu_out_if import ssu_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [63:0] rd_low;
  logic [63:0] rd_high;
  logic        upper_write;

  modport source (output valid, rd_low, rd_high, upper_write, input ready);
  modport sink (input valid, rd_low, rd_high, upper_write, output ready);
endinterface

>>> hdl/ssu_decode.sv
module ssu_decode import ssu_pkg::*; (
  input  logic [4:0]  cmd,
  input  logic [4:0]  imm_amount,
  input  logic [7:0]  funnel_amount,
  input  logic [5:0]  rs_amt_lo,
  input  logic [4:0]  rs_amt_hi,
  output ssu_ctl_t    ctl
);

  logic [7:0] sa;
  logic [7:0] sa32;
  logic [7:0] v6;
  logic [7:0] v5;

  assign sa   = 8'(imm_amount);
  assign sa32 = 8'(imm_amount) + DW_HIGH_OFFSET;
  assign v6   = 8'(rs_amt_lo);
  assign v5   = 8'(rs_amt_lo[4:0]);

  always_comb begin
    ctl.cls   = CLS_NONE;
    ctl.kind  = KIND_SRL;
    ctl.amt_a = '0;
    ctl.amt_b = '0;
    case (cmd_t'(cmd))
      CMD_DSRA:   begin ctl.cls = CLS_DW; ctl.kind = KIND_SRA; ctl.amt_a = sa;   end
      CMD_DSLL:   begin ctl.cls = CLS_DW; ctl.kind = KIND_SLL; ctl.amt_a = sa;   end
      CMD_DSLL32: begin ctl.cls = CLS_DW; ctl.kind = KIND_SLL; ctl.amt_a = sa32; end
      CMD_DSLLV:  begin ctl.cls = CLS_DW; ctl.kind = KIND_SLL; ctl.amt_a = v6;   end
      CMD_DSRA32: begin ctl.cls = CLS_DW; ctl.kind = KIND_SRA; ctl.amt_a = sa32; end
      CMD_DSRAV:  begin ctl.cls = CLS_DW; ctl.kind = KIND_SRA; ctl.amt_a = v6;   end
      CMD_DSRL:   begin ctl.cls = CLS_DW; ctl.kind = KIND_SRL; ctl.amt_a = sa;   end
      CMD_DSRL32: begin ctl.cls = CLS_DW; ctl.kind = KIND_SRL; ctl.amt_a = sa32; end
      CMD_DSRLV:  begin ctl.cls = CLS_DW; ctl.kind = KIND_SRL; ctl.amt_a = v6;   end
      CMD_SLL:    begin ctl.cls = CLS_W;  ctl.kind = KIND_SLL; ctl.amt_a = sa;   end
      CMD_SLLV:   begin ctl.cls = CLS_W;  ctl.kind = KIND_SLL; ctl.amt_a = v5;   end
      CMD_SRA:    begin ctl.cls = CLS_W;  ctl.kind = KIND_SRA; ctl.amt_a = sa;   end
      CMD_SRAV:   begin ctl.cls = CLS_W;  ctl.kind = KIND_SRA; ctl.amt_a = v5;   end
      CMD_SRL:    begin ctl.cls = CLS_W;  ctl.kind = KIND_SRL; ctl.amt_a = sa;   end
      CMD_SRLV:   begin ctl.cls = CLS_W;  ctl.kind = KIND_SRL; ctl.amt_a = v5;   end
      CMD_PSLLH, CMD_PSRAH, CMD_PSRLH: begin
        ctl.cls   = CLS_PH;
        ctl.kind  = (cmd_t'(cmd) == CMD_PSLLH) ? KIND_SLL :
                    (cmd_t'(cmd) == CMD_PSRAH) ? KIND_SRA : KIND_SRL;
        ctl.amt_a = 8'(imm_amount[3:0]);
      end
      CMD_PSLLW, CMD_PSRAW, CMD_PSRLW: begin
        ctl.cls   = CLS_PW;
        ctl.kind  = (cmd_t'(cmd) == CMD_PSLLW) ? KIND_SLL :
                    (cmd_t'(cmd) == CMD_PSRAW) ? KIND_SRA : KIND_SRL;
        ctl.amt_a = sa;
      end
      CMD_PSLLVW, CMD_PSRAVW, CMD_PSRLVW: begin
        ctl.cls   = CLS_VW;
        ctl.kind  = (cmd_t'(cmd) == CMD_PSLLVW) ? KIND_SLL :
                    (cmd_t'(cmd) == CMD_PSRAVW) ? KIND_SRA : KIND_SRL;
        ctl.amt_a = v5;
        ctl.amt_b = rs_amt_hi;
      end
      CMD_QFSRV: begin
        ctl.cls   = CLS_FUN;
        ctl.amt_a = funnel_amount;
      end
      default: ctl.cls = CLS_NONE;
    endcase
  end

endmodule

>>> hdl/simd_shift_unit_128.sv
// Channel  Dir  Payload                                                       Accept
// req      in   cmd, rt_low, rt_high, rs_low, rs_high, imm_amount, funnel_amount  valid & ready
// rsp      out  rd_low, rd_high, upper_write                                  valid & ready
//
// One transaction per cycle sustained unless rsp stalls; rsp.valid is the stage 3 valid bit.
// Stages: decode and operand register, coarse shift (multiples of 8), fine shift and format.
// rst is synchronous and clears the stage valid bits only.
// A stall on rsp holds a full stage only when all later stages are full; empty stages
// still fill, so req.ready stays high until all three stages hold a transaction.
`include "simd_shift_unit_128_defines.svh"

module simd_shift_unit_128 import ssu_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  ssu_in_if.sink    req,
  ssu_out_if.source rsp
);

  ssu_ctl_t           dec_ctl;

  logic               v1;
  logic               v2;
  logic               v3;
  logic               en1;
  logic               en2;
  logic               en3;

  ssu_ctl_t           ctl1;
  ssu_ctl_t           ctl2;
  logic [FUN_W-1:0]   data1;
  logic [MID_W-1:0]   data2;
  logic [MID_W-1:0]   data2_next;
  logic [QW-1:0]      fine;

  logic [63:0]        rd_low;
  logic [63:0]        rd_high;
  logic               upper_write;
  logic [63:0]        rd_low_next;
  logic [63:0]        rd_high_next;
  logic               upper_write_next;

  ssu_decode u_decode (
    .cmd           (req.cmd),
    .imm_amount    (req.imm_amount),
    .funnel_amount (req.funnel_amount),
    .rs_amt_lo     (req.rs_low[5:0]),
    .rs_amt_hi     (req.rs_high[4:0]),
    .ctl           (dec_ctl)
  );

  assign en3 = !v3 || rsp.ready;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign req.ready = en1;

  always_comb begin
    if (ctl1.cls == CLS_FUN) begin
      data2_next = MID_W'(data1 >> {ctl1.amt_a[7:3], 3'b000});
    end else begin
      data2_next = {8'b0, lane_shift(data1[QW-1:0], ctl1.cls, ctl1.kind,
                                     ctl1.amt_a & COARSE_MASK_A,
                                     ctl1.amt_b & COARSE_MASK_B)};
    end
  end

  always_comb begin
    if (ctl2.cls == CLS_FUN) begin
      fine = QW'(data2 >> ctl2.amt_a[2:0]);
    end else begin
      fine = lane_shift(data2[QW-1:0], ctl2.cls, ctl2.kind,
                        ctl2.amt_a & FINE_MASK_A, ctl2.amt_b & FINE_MASK_B);
    end
  end

  always_comb begin
    rd_low_next      = '0;
    rd_high_next     = '0;
    upper_write_next = 1'b0;
    case (ctl2.cls)
      CLS_DW: rd_low_next = fine[63:0];
      CLS_W:  rd_low_next = sext32(fine[31:0]);
      CLS_VW: begin
        rd_low_next      = sext32(fine[31:0]);
        rd_high_next     = sext32(fine[95:64]);
        upper_write_next = 1'b1;
      end
      CLS_PH, CLS_PW, CLS_FUN: begin
        rd_low_next      = fine[63:0];
        rd_high_next     = fine[127:64];
        upper_write_next = 1'b1;
      end
      default: upper_write_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= req.valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      ctl1  <= dec_ctl;
      data1 <= {req.rs_high, req.rs_low, req.rt_high, req.rt_low};
    end
    if (en2) begin
      ctl2  <= ctl1;
      data2 <= data2_next;
    end
    if (en3) begin
      rd_low      <= rd_low_next;
      rd_high     <= rd_high_next;
      upper_write <= upper_write_next;
    end
  end

  assign rsp.valid       = v3;
  assign rsp.rd_low      = rd_low;
  assign rsp.rd_high     = rd_high;
  assign rsp.upper_write = upper_write;

  `SSU_ASSERT_NEXT(a_accept_fills, req.valid && req.ready, v1, "accepted transaction lost")
  `SSU_ASSERT_NEXT(a_s1_moves, v1 && en2, v2, "stage 1 transaction dropped")
  `SSU_ASSERT_NEXT(a_s2_holds, v2 && !en3, v2 && $stable(data2) && $stable(ctl2),
                   "stage 2 changed under stall")
  `SSU_ASSERT_NOW(a_high_zero, v3 && !upper_write, rd_high == '0,
                  "rd_high nonzero without upper write")

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb import ssu_pkg::*; ();

  localparam logic [4:0] CMD_UNUSED_LAST = 5'd31;
  localparam int RANDOM_ITEMS = 1500;
  localparam logic [7:0] FUNNEL_EDGES [8] = '{8'd0, 8'd1, 8'd63, 8'd64, 8'd127, 8'd128,
                                              8'd191, 8'd255};

  typedef struct packed {
    logic [4:0]  cmd;
    logic [63:0] rt_low;
    logic [63:0] rt_high;
    logic [63:0] rs_low;
    logic [63:0] rs_high;
    logic [4:0]  imm_amount;
    logic [7:0]  funnel_amount;
  } shift_req_t;

  typedef struct packed {
    logic [63:0] rd_low;
    logic [63:0] rd_high;
    logic        upper_write;
  } shift_rsp_t;

  class shift_scoreboard;
    shift_rsp_t  pending_results[$];
    int unsigned mismatches;
    int unsigned accepted;
    int unsigned checked;
    logic [31:0] cmds_seen;

    function new();
      mismatches = 0;
      accepted = 0;
      checked = 0;
      cmds_seen = '0;
    endfunction

    static function logic [63:0] word_sx(logic [31:0] w, kind_t k, logic [4:0] s);
      logic [31:0] o;
      case (k)
        KIND_SLL: o = w << s;
        KIND_SRA: o = $signed(w) >>> s;
        default:  o = w >> s;
      endcase
      return {{32{o[31]}}, o};
    endfunction

    static function logic [15:0] half_shift(logic [15:0] h, kind_t k, logic [3:0] s);
      logic [15:0] o;
      case (k)
        KIND_SLL: o = h << s;
        KIND_SRA: o = $signed(h) >>> s;
        default:  o = h >> s;
      endcase
      return o;
    endfunction

    function shift_rsp_t shift_result(shift_req_t q);
      shift_rsp_t   r;
      logic [127:0] wide;
      logic [127:0] lanes;
      logic [255:0] funnel;
      logic [63:0]  sx;
      logic [5:0]   plus32;
      kind_t        k;
      r = '0;
      wide = {q.rt_high, q.rt_low};
      lanes = '0;
      plus32 = {1'b1, q.imm_amount};
      case (q.cmd)
        CMD_PSRAH, CMD_PSRAW, CMD_PSRAVW: k = KIND_SRA;
        CMD_PSRLH, CMD_PSRLW, CMD_PSRLVW: k = KIND_SRL;
        default: k = KIND_SLL;
      endcase
      case (q.cmd)
        CMD_DSRA:   r.rd_low = $signed(q.rt_low) >>> q.imm_amount;
        CMD_DSLL:   r.rd_low = q.rt_low << q.imm_amount;
        CMD_DSLL32: r.rd_low = q.rt_low << plus32;
        CMD_DSLLV:  r.rd_low = q.rt_low << q.rs_low[5:0];
        CMD_DSRA32: r.rd_low = $signed(q.rt_low) >>> plus32;
        CMD_DSRAV:  r.rd_low = $signed(q.rt_low) >>> q.rs_low[5:0];
        CMD_DSRL:   r.rd_low = q.rt_low >> q.imm_amount;
        CMD_DSRL32: r.rd_low = q.rt_low >> plus32;
        CMD_DSRLV:  r.rd_low = q.rt_low >> q.rs_low[5:0];
        CMD_SLL:    r.rd_low = word_sx(q.rt_low[31:0], KIND_SLL, q.imm_amount);
        CMD_SLLV:   r.rd_low = word_sx(q.rt_low[31:0], KIND_SLL, q.rs_low[4:0]);
        CMD_SRA:    r.rd_low = word_sx(q.rt_low[31:0], KIND_SRA, q.imm_amount);
        CMD_SRAV:   r.rd_low = word_sx(q.rt_low[31:0], KIND_SRA, q.rs_low[4:0]);
        CMD_SRL:    r.rd_low = word_sx(q.rt_low[31:0], KIND_SRL, q.imm_amount);
        CMD_SRLV:   r.rd_low = word_sx(q.rt_low[31:0], KIND_SRL, q.rs_low[4:0]);
        CMD_PSLLH, CMD_PSRAH, CMD_PSRLH: begin
          for (int i = 0; i < 8; i++)
            lanes[16*i +: 16] = half_shift(wide[16*i +: 16], k, q.imm_amount[3:0]);
          r.rd_low = lanes[63:0];
          r.rd_high = lanes[127:64];
          r.upper_write = 1'b1;
        end
        CMD_PSLLW, CMD_PSRAW, CMD_PSRLW: begin
          for (int i = 0; i < 4; i++) begin
            sx = word_sx(wide[32*i +: 32], k, q.imm_amount);
            lanes[32*i +: 32] = sx[31:0];
          end
          r.rd_low = lanes[63:0];
          r.rd_high = lanes[127:64];
          r.upper_write = 1'b1;
        end
        CMD_PSLLVW, CMD_PSRAVW, CMD_PSRLVW: begin
          r.rd_low = word_sx(q.rt_low[31:0], k, q.rs_low[4:0]);
          r.rd_high = word_sx(q.rt_high[31:0], k, q.rs_high[4:0]);
          r.upper_write = 1'b1;
        end
        CMD_QFSRV: begin
          funnel = {q.rs_high, q.rs_low, q.rt_high, q.rt_low} >> q.funnel_amount;
          r.rd_low = funnel[63:0];
          r.rd_high = funnel[127:64];
          r.upper_write = 1'b1;
        end
        default: r = '0;
      endcase
      return r;
    endfunction

    function void note_request(shift_req_t q);
      pending_results.push_back(shift_result(q));
      accepted++;
      cmds_seen[q.cmd] = 1'b1;
    endfunction

    function void report(string field, logic [63:0] exp_val, logic [63:0] act_val);
      mismatches++;
      if (mismatches <= 30)
        $error("%s: expected %h, actual %h (result %0d)", field, exp_val, act_val, checked);
    endfunction

    function void check_response(shift_rsp_t a);
      shift_rsp_t e;
      if (pending_results.size() == 0) begin
        report("unexpected result rd_low", '0, a.rd_low);
        return;
      end
      e = pending_results.pop_front();
      checked++;
      if (a.rd_low !== e.rd_low) report("rd_low", e.rd_low, a.rd_low);
      if (a.rd_high !== e.rd_high) report("rd_high", e.rd_high, a.rd_high);
      if (a.upper_write !== e.upper_write)
        report("upper_write", 64'(e.upper_write), 64'(a.upper_write));
    endfunction

    function int unsigned outstanding();
      return pending_results.size();
    endfunction

    function void flag_leftover();
      if (pending_results.size() != 0) begin
        $error("%0d results never arrived", pending_results.size());
        mismatches += pending_results.size();
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;

  ssu_in_if  req();
  ssu_out_if rsp();

  simd_shift_unit_128 dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  shift_scoreboard sb = new();

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (!rst && req.valid && req.ready)
      sb.note_request(shift_req_t'{cmd: req.cmd, rt_low: req.rt_low, rt_high: req.rt_high,
                                   rs_low: req.rs_low, rs_high: req.rs_high,
                                   imm_amount: req.imm_amount,
                                   funnel_amount: req.funnel_amount});
    if (!rst && rsp.valid && rsp.ready)
      sb.check_response(shift_rsp_t'{rd_low: rsp.rd_low, rd_high: rsp.rd_high,
                                     upper_write: rsp.upper_write});
  end

  initial begin
    rsp.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (sink_idle_pct != 0 && $urandom_range(1, 100) <= sink_idle_pct) begin
        rsp.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        rsp.ready <= 1'b1;
      end
    end
  end

  function automatic logic [63:0] rand_dword();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return 64'h8000_0000_0000_0000;
      3: return 64'h8000_8000_8000_8000;
      4: return 64'h7FFF_FFFF_8000_0000;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic shift_req_t random_request();
    shift_req_t t;
    if ($urandom_range(0, 15) == 0)
      t.cmd = 5'($urandom_range(CMD_QFSRV + 1, CMD_UNUSED_LAST));
    else
      t.cmd = 5'($urandom_range(CMD_DSRA, CMD_QFSRV));
    t.rt_low = rand_dword();
    t.rt_high = rand_dword();
    t.rs_low = {$urandom, $urandom};
    t.rs_high = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: t.imm_amount = '0;
      1: t.imm_amount = '1;
      default: t.imm_amount = 5'($urandom);
    endcase
    if ($urandom_range(0, 2) == 0)
      t.funnel_amount = FUNNEL_EDGES[$urandom_range(0, 7)];
    else
      t.funnel_amount = 8'($urandom);
    return t;
  endfunction

  task automatic send_item(input shift_req_t t);
    req.valid <= 1'b1;
    req.cmd <= t.cmd;
    req.rt_low <= t.rt_low;
    req.rt_high <= t.rt_high;
    req.rs_low <= t.rs_low;
    req.rs_high <= t.rs_high;
    req.imm_amount <= t.imm_amount;
    req.funnel_amount <= t.funnel_amount;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    if (src_idle_pct != 0 && $urandom_range(1, 100) <= src_idle_pct) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  task automatic hold_until_drained();
    req.valid <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
  endtask

  initial begin
    shift_req_t t;
    src_idle_pct = 0;
    sink_idle_pct = 0;
    rst <= 1'b1;
    req.valid <= 1'b0;
    req.cmd <= '0;
    req.rt_low <= '0;
    req.rt_high <= '0;
    req.rs_low <= '0;
    req.rs_high <= '0;
    req.imm_amount <= '0;
    req.funnel_amount <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    t = '0;
    send_item(t);
    for (int c = CMD_DSRA; c <= CMD_PSRLW; c++) begin
      t.cmd = 5'(c);
      t.rt_low = c[0] ? 64'h8001_7FFF_8000_FFFF : 64'h7FFF_8000_0001_8000;
      t.rt_high = ~t.rt_low;
      t.rs_low = c[0] ? 64'hFFFF_FFFF_FFFF_FFFF : 64'hFFFF_FFFF_FFFF_FFC0;
      t.rs_high = c[0] ? 64'h0000_0000_0000_001F : 64'hFFFF_FFFF_FFFF_FFE0;
      t.imm_amount = c[0] ? 5'd31 : 5'd0;
      t.funnel_amount = 8'(c);
      send_item(t);
    end
    t.cmd = CMD_QFSRV;
    t.rt_low = 64'h0123_4567_89AB_CDEF;
    t.rt_high = 64'hFEDC_BA98_7654_3210;
    t.rs_low = 64'hA5A5_5A5A_F00F_0FF0;
    t.rs_high = 64'h8000_0000_0000_0001;
    for (int a = 0; a < 8; a += 2) begin
      t.funnel_amount = FUNNEL_EDGES[a + (a >= 4 ? 1 : 0)];
      send_item(t);
    end
    t.funnel_amount = 8'd255;
    send_item(t);
    t = '1;
    t.cmd = CMD_UNUSED_LAST;
    send_item(t);
    hold_until_drained();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 0) begin
        src_idle_pct = 20;
        sink_idle_pct = 20;
      end else if (n == 400) begin
        src_idle_pct = 0;
        sink_idle_pct = 50;
      end else if (n == 700) begin
        hold_until_drained();
        src_idle_pct = 50;
        sink_idle_pct = 5;
      end else if (n == 1000) begin
        src_idle_pct = 30;
        sink_idle_pct = 30;
      end else if (n == 1200) begin
        src_idle_pct = 0;
        sink_idle_pct = 0;
      end
      send_item(random_request());
    end
    req.valid <= 1'b0;

    repeat (5000) begin
      if (sb.outstanding() == 0) break;
      @(posedge clk);
    end
    repeat (10) @(posedge clk);
    sb.flag_leftover();

    $display("Run covered %0d transactions, %0d results checked, %0d of 32 command codes",
             sb.accepted, sb.checked, $countones(sb.cmds_seen));
    $display("(all shift classes, funnel amounts 0..255, unused codes, handshake stalls).");
    if (sb.mismatches == 0) begin
      $display("** simd_shift_unit_128: PASSED **");
    end else begin
      $display("** simd_shift_unit_128: FAILED **");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout: run did not complete");
    $display("** simd_shift_unit_128: FAILED **");
    $finish;
  end

endmodule
